// File: hw/rtl/fca_pkg.sv
// fca_pkg: constants, codes and types for the cluster chain allocator.
// Depends on nothing; used by hw/rtl/fat_chain_allocator.sv.

package fca_pkg;

	// table geometry
	localparam int unsigned TABLE_DEPTH = 256;
	localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
	localparam int unsigned FREE_W      = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned MAX_RUN     = 64;
	localparam int unsigned COUNT_W     = 7;
	localparam int unsigned LINK_W      = 9;

	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [FREE_W-1:0]         free_t;
	typedef logic [COUNT_W-1:0]        cnt_t;
	typedef logic signed [LINK_W-1:0]  link_t;

	// link contents
	localparam link_t LINK_UNUSED = -9'sd2;
	localparam link_t LINK_END    = -9'sd1;
	localparam link_t LINK_NONE   = 9'sd0;

	// function codes
	localparam logic [1:0] FN_ALLOC  = 2'd0;
	localparam logic [1:0] FN_READ   = 2'd1;
	localparam logic [1:0] FN_FORMAT = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_BAD     = 2'd2;

	localparam free_t FREE_FULL = free_t'(TABLE_DEPTH);
	localparam cnt_t  RUN_MAX   = cnt_t'(MAX_RUN);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_FIN  = 5'b00100,
		S_RD   = 5'b01000,
		S_RDW  = 5'b10000
	} state_t;

endpackage

// File: hw/rtl/fat_chain_allocator.sv
// fat_chain_allocator: file allocation table with chain allocation, read and format.
// Depends on fca_pkg (hw/rtl/fca_pkg.sv).
//
//   channel  dir  handshake           word
//   in       in   in_valid/in_stall   func, count, prev_valid, entry
//   out      out  out_valid/out_stall status, entry_index, link_value, free_count, last
//
// Allocate of n entries scans the table one entry per cycle from entry 0 while the output
// word can move; one word per claimed entry. Read passes through S_RD and S_RDW (registered
// link RAM read). Format, rejects and unknown func answer from S_IDLE with one word.
// One word is in flight at a time.
// Reset: per-entry in-use flags clear at once, so no clearing pass; free count = TABLE_DEPTH.
// Stalls: out_stall holds the output register and pauses the scan; in_stall is high
// while an operation is open or the output register cannot take a word.

module fat_chain_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [fca_pkg::COUNT_W-1:0]   count,
	input  logic                          prev_valid,
	input  logic [7:0]                    entry,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [7:0]                    entry_index,
	output logic signed [8:0]             link_value,
	output logic [8:0]                    free_count,
	output logic                          last
);

	// link RAM: holds links of in-use entries only; in-use flags say which
	fca_pkg::link_t mem [fca_pkg::TABLE_DEPTH];
	fca_pkg::link_t rd_data_q;

	logic [fca_pkg::TABLE_DEPTH-1:0] used_q;

	fca_pkg::state_t state_q;
	fca_pkg::free_t  free_q;
	fca_pkg::cnt_t   count_q;
	fca_pkg::cnt_t   found_q;
	fca_pkg::idx_t   entry_q;
	fca_pkg::idx_t   scan_q;
	fca_pkg::idx_t   prev_q;
	logic            tail_q;

	// output register
	logic            out_valid_q;
	logic [1:0]      status_q;
	fca_pkg::idx_t   index_q;
	fca_pkg::link_t  link_q;
	fca_pkg::free_t  ofree_q;
	logic            last_q;

	logic out_free;
	logic accept;

	// next-cycle controls
	fca_pkg::state_t state_d;
	logic            emit;
	logic [1:0]      e_status;
	fca_pkg::idx_t   e_index;
	fca_pkg::link_t  e_link;
	fca_pkg::free_t  e_free;
	logic            wr_en;
	fca_pkg::idx_t   wr_addr;
	fca_pkg::link_t  wr_data;
	logic            claim;
	logic            fmt;
	logic            take_scan;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == fca_pkg::S_IDLE) && out_free);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		e_status  = fca_pkg::ST_OK;
		e_index   = '0;
		e_link    = fca_pkg::LINK_NONE;
		e_free    = free_q;
		wr_en     = 1'b0;
		wr_addr   = prev_q;
		wr_data   = fca_pkg::LINK_END;
		claim     = 1'b0;
		fmt       = 1'b0;
		take_scan = 1'b0;
		unique case (state_q)
			fca_pkg::S_IDLE: begin
				if (accept) begin
					case (func)
						fca_pkg::FN_ALLOC: begin
							if (count == '0 || count > fca_pkg::RUN_MAX) begin
								emit     = 1'b1;
								e_status = fca_pkg::ST_BAD;
							end else if (free_q < fca_pkg::free_t'(count)) begin
								emit     = 1'b1;
								e_status = fca_pkg::ST_NO_FREE;
							end else begin
								take_scan = 1'b1;
								state_d   = fca_pkg::S_SCAN;
							end
						end
						fca_pkg::FN_READ: begin
							state_d = fca_pkg::S_RD;
						end
						fca_pkg::FN_FORMAT: begin
							fmt    = 1'b1;
							emit   = 1'b1;
							e_free = fca_pkg::FREE_FULL;
						end
						default: begin
							emit     = 1'b1;
							e_status = fca_pkg::ST_BAD;
						end
					endcase
				end
			end
			fca_pkg::S_SCAN: begin
				// one entry per cycle; paused while the output word cannot move
				if (out_free && !used_q[scan_q]) begin
					claim = 1'b1;
					if (found_q == '0) begin
						// hook an existing chain tail onto the first new entry
						wr_en   = tail_q;
						wr_addr = entry_q;
						wr_data = fca_pkg::link_t'({1'b0, scan_q});
					end else begin
						wr_en    = 1'b1;
						wr_addr  = prev_q;
						wr_data  = fca_pkg::link_t'({1'b0, scan_q});
						emit     = 1'b1;
						e_index  = prev_q;
						e_link   = fca_pkg::link_t'({1'b0, scan_q});
						e_free   = free_q - 1'b1;
					end
					if (found_q + 1'b1 == count_q)
						state_d = fca_pkg::S_FIN;
				end
			end
			fca_pkg::S_FIN: begin
				if (out_free) begin
					wr_en   = 1'b1;
					wr_addr = prev_q;
					wr_data = fca_pkg::LINK_END;
					emit    = 1'b1;
					e_index = prev_q;
					e_link  = fca_pkg::LINK_END;
					e_free  = free_q - 1'b1;
					state_d = fca_pkg::S_IDLE;
				end
			end
			fca_pkg::S_RD: begin
				state_d = fca_pkg::S_RDW;
			end
			fca_pkg::S_RDW: begin
				if (out_free) begin
					emit    = 1'b1;
					e_index = entry_q;
					e_link  = used_q[entry_q] ? rd_data_q : fca_pkg::LINK_UNUSED;
					state_d = fca_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fca_pkg::S_IDLE;
			end
		endcase
	end

	// link RAM, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_q <= mem[entry_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fca_pkg::S_IDLE;
			used_q      <= '0;
			free_q      <= fca_pkg::FREE_FULL;
			found_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fmt)
				used_q <= '0;
			else if (claim)
				used_q[scan_q] <= 1'b1;
			if (emit)
				free_q <= e_free;
			if (take_scan)
				found_q <= '0;
			else if (claim)
				found_q <= found_q + 1'b1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_q <= count;
			entry_q <= entry;
			tail_q  <= prev_valid && used_q[entry];
		end
		if (take_scan)
			scan_q <= '0;
		else if (state_q == fca_pkg::S_SCAN && out_free)
			scan_q <= scan_q + 1'b1;
		if (claim)
			prev_q <= scan_q;
		if (emit) begin
			status_q <= e_status;
			index_q  <= e_index;
			link_q   <= e_link;
			ofree_q  <= e_free;
			last_q   <= (e_status != fca_pkg::ST_OK) || (state_q != fca_pkg::S_SCAN);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_index = index_q;
	assign link_value  = link_q;
	assign free_count  = ofree_q;
	assign last        = last_q;

	// a word is only loaded when the output register can give up its old one
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("word loaded over a stalled word");

	// scan closes exactly when the requested run is claimed
	a_fin_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fca_pkg::S_FIN) |-> (found_q == count_q))
		else $error("chain end reached with wrong claim count");

	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fca_pkg::S_SCAN) |-> (found_q < count_q))
		else $error("scan claimed more than requested");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= fca_pkg::FREE_FULL)
		else $error("free count above table depth");

	a_format: assert property (@(posedge clk) disable iff (!arst_n)
		fmt |=> (free_q == fca_pkg::FREE_FULL) && (used_q == '0))
		else $error("format left entries in use");

endmodule
